[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the slew limiter.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/hbps_pkg.sv]
// Types and constants of the H-bridge PWM slew limiter.
// No dependencies; used by every module of the block.
package hbps_pkg;

  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Result queue depth: a power of two, at least two (one full flip).
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [DUTY_W-1:0] DUTY_MAX     = 8'd255;
  localparam logic [DUTY_W-1:0] ACCEL_RESET  = 8'd16;
  localparam logic [DUTY_W-1:0] BRAKE_RESET  = 8'd32;

  typedef enum logic {
    REQ_SET_DUTY   = 1'b0,
    REQ_SET_ENABLE = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL = 1'b0,
    CFG_BRAKE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              req_type;
    logic [DUTY_W-1:0] duty_request;
    logic              want_forward;
    logic              force_flip;
    logic              enable_value;
  } in_item_t;

  typedef struct packed {
    logic              forward_pin;
    logic              backward_pin;
    logic [DUTY_W-1:0] duty_out;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] accel_step_limit;
    logic [DUTY_W-1:0] brake_step_limit;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              forward;
    logic              enabled;
  } state_t;

  // Outcome of one request: first beat, optional second beat.
  typedef struct packed {
    out_item_t beat0;
    out_item_t beat1;
    logic      two;
  } step_t;

endpackage

[hdl/hbps_step.sv]
// Combinational step of the slew limiter: slew, clamp and bridge pin logic.
// Depends on hbps_pkg.
module hbps_step (
  input  hbps_pkg::in_item_t item,
  input  hbps_pkg::state_t   cur,
  input  hbps_pkg::cfg_t     cfg,
  output hbps_pkg::state_t   nxt,
  output hbps_pkg::step_t    res
);

  logic                      flip;
  logic [hbps_pkg::DUTY_W-1:0] slewed;
  logic [hbps_pkg::DUTY_W-1:0] diff_up;
  logic [hbps_pkg::DUTY_W-1:0] diff_dn;
  logic [hbps_pkg::DUTY_W:0]   sum_up;
  hbps_pkg::out_item_t         final_beat;
  hbps_pkg::out_item_t         dead_beat;

  assign flip    = item.want_forward != cur.forward;
  assign diff_up = item.duty_request - cur.duty;
  assign diff_dn = cur.duty - item.duty_request;
  assign sum_up  = {1'b0, cur.duty} + {1'b0, cfg.accel_step_limit};

  always_comb begin
    slewed = item.duty_request;
    if (item.duty_request > cur.duty) begin
      if (diff_up > cfg.accel_step_limit) begin
        slewed = sum_up[hbps_pkg::DUTY_W] ? hbps_pkg::DUTY_MAX
                                          : sum_up[hbps_pkg::DUTY_W-1:0];
      end
    end else if (item.duty_request < cur.duty) begin
      if (diff_dn > cfg.brake_step_limit) begin
        slewed = (cur.duty > cfg.brake_step_limit) ? cur.duty - cfg.brake_step_limit
                                                   : '0;
      end
    end
  end

  always_comb begin
    nxt = cur;
    unique case (hbps_pkg::req_type_e'(item.req_type))
      hbps_pkg::REQ_SET_ENABLE: nxt.enabled = item.enable_value;
      hbps_pkg::REQ_SET_DUTY: begin
        nxt.duty    = (item.force_flip && flip) ? item.duty_request : slewed;
        nxt.forward = item.want_forward;
      end
      default: nxt = cur;
    endcase
  end

  always_comb begin
    final_beat.forward_pin  = nxt.enabled && nxt.forward;
    final_beat.backward_pin = nxt.enabled && !nxt.forward;
    final_beat.duty_out     = nxt.enabled ? nxt.duty : '0;
    final_beat.last         = 1'b1;

    // Dead time: both bridge inputs low, old duty still driven.
    dead_beat.forward_pin   = 1'b0;
    dead_beat.backward_pin  = 1'b0;
    dead_beat.duty_out      = cur.enabled ? cur.duty : '0;
    dead_beat.last          = 1'b0;

    if (item.req_type == hbps_pkg::REQ_SET_DUTY && flip) begin
      res.beat0 = dead_beat;
      res.beat1 = final_beat;
      res.two   = 1'b1;
    end else begin
      res.beat0 = final_beat;
      res.beat1 = final_beat;
      res.two   = 1'b0;
    end
  end

endmodule

[hdl/hbps_out_fifo.sv]
// Result queue: takes one or two beats a cycle, hands out one a cycle while pop is high and it is not empty.
// Depends on hbps_pkg.
module hbps_out_fifo (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  hbps_pkg::step_t                           push_data,
  input  logic                                      pop,
  output logic                                      out_valid,
  output hbps_pkg::out_item_t                       out_item,
  output logic [$clog2(hbps_pkg::FIFO_DEPTH+1)-1:0] count
);

  localparam int unsigned DEPTH = hbps_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  hbps_pkg::out_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    n_push;
  logic                do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign n_push    = push ? (push_data.two ? CNT_W'(2) : CNT_W'(1)) : '0;
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(do_pop);
  assign cnt_nxt    = cnt_r + n_push - CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data.beat0;
      if (push_data.two) begin
        mem_r[wr_ptr_r + PTR_W'(1)] <= push_data.beat1;
      end
    end
  end

  assign out_valid = cnt_r != '0;
  assign out_item  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

[hdl/hbridge_pwm_slew_limiter_unit.sv]
// Top level of the H-bridge PWM slew limiter.
// Depends on hbps_pkg, hbps_step, hbps_out_fifo and assert_macros.svh.
//
//   Input channel (in_valid / in_stall / in_item): one beat is one request,
//   either set duty and direction or set enable. A beat is taken on a rising
//   edge with in_valid high and in_stall low.
//   Result channel (out_valid / out_stall / out_item): one beat per result.
//   An enable request or a duty request in the same direction gives one
//   beat; a direction flip gives a dead-time beat (both pins low, last 0)
//   followed by the beat with the new pins (last 1).
//   Config port (cfg_wr_en / cfg_index / cfg_wdata): index 0 is the
//   acceleration step, index 1 the braking step; write only while idle.
//   Path: a taken beat waits in the input register until the result queue
//   has room for two beats, is then stepped and pushed, and is offered from there.
//   Throughput: one request per cycle while the queue has room, as the step
//   logic between the input register and the result queue is combinational;
//   a flip adds a second output beat, so a run of flips fills the queue.
//   Stall: while out_stall is high the queue fills; once it lacks room for
//   two beats the input register holds and in_stall rises.
//   Reset (rst_n low, synchronous): duty 0, forward, disabled, steps 16/32.
`include "assert_macros.svh"
module hbridge_pwm_slew_limiter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hbps_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hbps_pkg::out_item_t               out_item,
  input  logic                              cfg_wr_en,
  input  logic [hbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbps_pkg::DUTY_W-1:0]       cfg_wdata
);

  localparam int unsigned FIFO_DEPTH = hbps_pkg::FIFO_DEPTH;
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH+1);

  // Input register
  logic                 in_v_r, in_v_nxt;
  hbps_pkg::in_item_t   in_item_r;
  logic                 in_acc;
  logic                 advance;

  // Channel state and configuration
  hbps_pkg::state_t     state_r, state_nxt;
  hbps_pkg::cfg_t       cfg_r;
  hbps_pkg::step_t      step_res;

  logic [CNT_W-1:0]     fifo_cnt;
  logic                 room2;

  // Result beat classification for the checks
  logic                 dead_shown;
  logic                 dead_taken;
  logic                 final_shown;
  logic                 pins_low;

  // Advance only when the queue can hold a full flip (two beats).
  assign room2    = fifo_cnt <= CNT_W'(FIFO_DEPTH - 2);
  assign advance  = in_v_r && room2;
  assign in_stall = in_v_r && !room2;
  assign in_acc   = in_valid && !in_stall;
  assign in_v_nxt = in_acc ? 1'b1 : (advance ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_item;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_step_limit <= hbps_pkg::ACCEL_RESET;
      cfg_r.brake_step_limit <= hbps_pkg::BRAKE_RESET;
    end else if (cfg_wr_en) begin
      unique case (hbps_pkg::cfg_reg_e'(cfg_index))
        hbps_pkg::CFG_ACCEL: cfg_r.accel_step_limit <= cfg_wdata;
        hbps_pkg::CFG_BRAKE: cfg_r.brake_step_limit <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  hbps_step u_step (
    .item (in_item_r),
    .cur  (state_r),
    .cfg  (cfg_r),
    .nxt  (state_nxt),
    .res  (step_res)
  );

  // Commit the channel state only when the request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.duty    <= '0;
      state_r.forward <= 1'b1;
      state_r.enabled <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  hbps_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .push_data (step_res),
    .pop       (!out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .count     (fifo_cnt)
  );

  assign dead_shown  = out_valid && !out_item.last;
  assign dead_taken  = dead_shown && !out_stall;
  assign final_shown = out_valid && out_item.last;
  assign pins_low    = !out_item.forward_pin && !out_item.backward_pin;

  // Checks
  `ASSERT_CLK(a_fifo_bound, fifo_cnt <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_CLK(a_stall_needs_item, !in_v_r |-> !in_stall, "stall with input register empty")
  `ASSERT_CLK(a_dead_then_final, dead_taken |=> final_shown, "dead-time beat without final beat")
  `ASSERT_CLK(a_dead_pins_low, dead_shown |-> pins_low, "dead-time beat drives a bridge pin")

endmodule

[bench/hbps_bridge_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the H-bridge PWM slew limiter: watches the request, result
// and step-limit ports, predicts every result beat and compares it.
// Depends on hbps_pkg for the beat types and codes.
module hbps_bridge_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  hbps_pkg::in_item_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  hbps_pkg::out_item_t            out_item,
  input  logic                           cfg_wr_en,
  input  logic [hbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbps_pkg::DUTY_W-1:0]    cfg_wdata,
  output int                             fail_count,
  output int                             beats_pending
);

  localparam int REPORT_LIMIT = 10;
  localparam int DW           = hbps_pkg::DUTY_W;

  // Shadow copy of the bridge state and step limits
  logic [DW-1:0] accel_limit;
  logic [DW-1:0] brake_limit;
  logic [DW-1:0] bridge_duty;
  logic          bridge_forward;
  logic          bridge_enabled;

  hbps_pkg::out_item_t expected_beats[$];

  function automatic logic [DW-1:0] limit_slew(logic [DW-1:0] cur,
                                               logic [DW-1:0] want,
                                               logic [DW-1:0] rise,
                                               logic [DW-1:0] fall);
    int c = cur;
    int w = want;
    if (w > c) begin
      if (w - c > rise)
        return (c + rise > hbps_pkg::DUTY_MAX) ? hbps_pkg::DUTY_MAX : DW'(c + rise);
    end else if (w < c) begin
      if (c - w > fall) return (c > fall) ? DW'(c - fall) : '0;
    end
    return want;
  endfunction

  // Pins and duty as driven from the current state, closing the request
  function automatic hbps_pkg::out_item_t settled_beat();
    hbps_pkg::out_item_t b;
    b.forward_pin  = bridge_enabled & bridge_forward;
    b.backward_pin = bridge_enabled & ~bridge_forward;
    b.duty_out     = bridge_enabled ? bridge_duty : '0;
    b.last         = 1'b1;
    return b;
  endfunction

  task automatic predict_request(input hbps_pkg::in_item_t req);
    hbps_pkg::out_item_t dead;
    logic                flip;
    if (req.req_type == hbps_pkg::REQ_SET_ENABLE) begin
      bridge_enabled = req.enable_value;
      expected_beats.push_back(settled_beat());
      return;
    end
    flip = req.want_forward != bridge_forward;
    if (flip) begin
      // Dead time: both pins low, old duty still shown
      dead.forward_pin  = 1'b0;
      dead.backward_pin = 1'b0;
      dead.duty_out     = bridge_enabled ? bridge_duty : '0;
      dead.last         = 1'b0;
      expected_beats.push_back(dead);
    end
    bridge_duty = (flip && req.force_flip) ? req.duty_request :
                  limit_slew(bridge_duty, req.duty_request, accel_limit, brake_limit);
    bridge_forward = req.want_forward;
    expected_beats.push_back(settled_beat());
  endtask

  task automatic report_fault(input string what, input hbps_pkg::out_item_t want_b,
                              input hbps_pkg::out_item_t got_b);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t: %s: expected fwd=%0b bwd=%0b duty=%0d last=%0b, %s",
               $realtime, what, want_b.forward_pin, want_b.backward_pin,
               want_b.duty_out, want_b.last,
               $sformatf("got fwd=%0b bwd=%0b duty=%0d last=%0b",
                         got_b.forward_pin, got_b.backward_pin, got_b.duty_out,
                         got_b.last));
  endtask

  initial begin
    fail_count    = 0;
    beats_pending = 0;
  end

  always @(posedge clk) begin
    hbps_pkg::out_item_t want_b;
    if (!rst_n) begin
      accel_limit    = hbps_pkg::ACCEL_RESET;
      brake_limit    = hbps_pkg::BRAKE_RESET;
      bridge_duty    = '0;
      bridge_forward = 1'b1;
      bridge_enabled = 1'b0;
      expected_beats.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == hbps_pkg::CFG_ACCEL) accel_limit = cfg_wdata;
        else if (cfg_index == hbps_pkg::CFG_BRAKE) brake_limit = cfg_wdata;
      end
      // Retire before predicting: a beat never belongs to this edge's request
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          want_b = '0;
          report_fault("unexpected beat", want_b, out_item);
        end else begin
          want_b = expected_beats.pop_front();
          if (out_item.forward_pin !== want_b.forward_pin ||
              out_item.backward_pin !== want_b.backward_pin ||
              out_item.duty_out !== want_b.duty_out ||
              out_item.last !== want_b.last)
            report_fault("beat mismatch", want_b, out_item);
        end
      end
      if (in_valid && !in_stall) predict_request(in_item);
    end
    beats_pending = expected_beats.size();
  end

endmodule

[bench/hbridge_pwm_slew_limiter_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for hbridge_pwm_slew_limiter_unit: drives requests, result
// back-pressure and step-limit writes; hbps_bridge_checker does the checking.
// Depends on hbps_pkg, hbps_bridge_checker and the block's RTL.
module hbridge_pwm_slew_limiter_unit_tb;

  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest correct run
  localparam int SETTLE_CYCLES = 6;       // idle margin after the queue drains
  localparam int LONG_HOLD     = 80;      // receiver hold-off, fills the queue
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 300;
  localparam int DW            = hbps_pkg::DUTY_W;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  hbps_pkg::in_item_t             in_item;
  logic                           out_valid;
  logic                           out_stall;
  hbps_pkg::out_item_t            out_item;
  logic                           cfg_wr_en;
  logic [hbps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0]                  cfg_wdata;

  int fail_count;
  int beats_pending;
  int cycle_count;

  // Stimulus shaping, each written by the main process only
  bit            idling_on;
  int            rx_holds_asked;
  logic          tx_forward;
  logic [DW-1:0] tx_duty;

  // Written by the receiver process only
  int rx_holds_done;

  hbridge_pwm_slew_limiter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  hbps_bridge_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .beats_pending (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[hbridge_pwm_slew_limiter_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts while idling is on, and a long hold-off
  // whenever the main process asks for one. Changes land on the falling edge.
  initial begin
    out_stall     = 1'b0;
    rx_holds_done = 0;
    forever begin
      @(negedge clk);
      if (rx_holds_asked > rx_holds_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        rx_holds_done++;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Unused fields of each request carry random bits: the block must ignore them
  function automatic hbps_pkg::in_item_t duty_beat(logic [DW-1:0] duty, logic fwd,
                                                   logic force_it);
    hbps_pkg::in_item_t r;
    r.req_type     = hbps_pkg::REQ_SET_DUTY;
    r.duty_request = duty;
    r.want_forward = fwd;
    r.force_flip   = force_it;
    r.enable_value = 1'($urandom);
    return r;
  endfunction

  function automatic hbps_pkg::in_item_t enable_beat(logic en);
    hbps_pkg::in_item_t r;
    r.req_type     = hbps_pkg::REQ_SET_ENABLE;
    r.duty_request = DW'($urandom);
    r.want_forward = 1'($urandom);
    r.force_flip   = 1'($urandom);
    r.enable_value = en;
    return r;
  endfunction

  // Offer one beat from a falling edge and hold it until taken; return on
  // the falling edge after acceptance with valid still high.
  task automatic send_request(input hbps_pkg::in_item_t req);
    in_item  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, let every expected beat drain, then load both step limits.
  task automatic load_step_limits(input logic [DW-1:0] accel,
                                  input logic [DW-1:0] brake);
    in_valid <= 1'b0;
    wait (beats_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= hbps_pkg::CFG_ACCEL;
    cfg_wdata <= accel;
    @(negedge clk);
    cfg_index <= hbps_pkg::CFG_BRAKE;
    cfg_wdata <= brake;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed motor traffic: occasional flips, duty walking near the
  // last request with jumps to the rails, and some enable requests
  function automatic hbps_pkg::in_item_t random_request();
    int pick;
    if ($urandom_range(0, 99) < 12) return enable_beat($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 3) == 0) tx_forward = ~tx_forward;
    pick = $urandom_range(0, 9);
    if (pick == 0) tx_duty = '0;
    else if (pick == 1) tx_duty = hbps_pkg::DUTY_MAX;
    else if (pick < 5) tx_duty = DW'(int'(tx_duty) + $urandom_range(0, 40) - 20);
    else tx_duty = DW'($urandom);
    return duty_beat(tx_duty, tx_forward, 1'($urandom));
  endfunction

  initial begin
    logic [DW-1:0] accel;
    logic [DW-1:0] brake;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = hbps_pkg::CFG_ACCEL;
    cfg_wdata      = '0;
    idling_on      = 1'b1;
    rx_holds_asked = 0;
    tx_forward     = 1'b1;
    tx_duty        = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset limits first (rise 16, fall 32)
    send_request(enable_beat(1'b0));             // enable off while already off
    send_request(duty_beat(8'd200, 1'b1, 1'b0)); // duty still moves while disabled
    send_request(enable_beat(1'b1));
    send_request(duty_beat(hbps_pkg::DUTY_MAX, 1'b1, 1'b0)); // rise held to the step
    send_request(duty_beat(8'd32, 1'b1, 1'b1));  // equal duty, force without flip
    send_request(duty_beat(8'd0, 1'b1, 1'b0));   // fall by exactly the step
    send_request(duty_beat(8'd0, 1'b1, 1'b0));   // equal at zero
    send_request(duty_beat(hbps_pkg::DUTY_MAX, 1'b0, 1'b0)); // flip, still slew limited
    send_request(duty_beat(hbps_pkg::DUTY_MAX, 1'b1, 1'b1)); // forced flip takes the rail
    send_request(duty_beat(hbps_pkg::DUTY_MAX, 1'b1, 1'b1)); // force ignored, no flip
    send_request(duty_beat(8'd0, 1'b0, 1'b1));   // forced flip down to zero
    send_request(enable_beat(1'b0));
    send_request(duty_beat(8'd100, 1'b1, 1'b1)); // flip while disabled
    send_request(enable_beat(1'b0));
    send_request(enable_beat(1'b1));

    load_step_limits(hbps_pkg::DUTY_MAX, hbps_pkg::DUTY_MAX);
    send_request(duty_beat(hbps_pkg::DUTY_MAX, 1'b1, 1'b0));
    send_request(duty_beat(8'd0, 1'b1, 1'b0));

    // Zero steps freeze the duty unless a forced flip bypasses them
    load_step_limits(8'd0, 8'd0);
    send_request(duty_beat(hbps_pkg::DUTY_MAX, 1'b1, 1'b0));
    send_request(duty_beat(8'd200, 1'b0, 1'b1));
    send_request(duty_beat(8'd0, 1'b0, 1'b0));

    load_step_limits(8'd1, 8'd1);
    send_request(duty_beat(hbps_pkg::DUTY_MAX, 1'b0, 1'b0));
    send_request(duty_beat(8'd0, 1'b0, 1'b0));
    tx_forward = 1'b0;
    tx_duty    = 8'd200;

    // Random part: one limit setting per phase, loaded while the block is idle
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin accel = 8'd1;  brake = hbps_pkg::DUTY_MAX; end
        1: begin accel = hbps_pkg::DUTY_MAX; brake = 8'd1; end
        2: begin accel = 8'd0;  brake = DW'($urandom); end
        3: begin accel = DW'($urandom); brake = 8'd0; end
        default: begin
          accel = DW'($urandom_range(1, 255));
          brake = DW'($urandom_range(1, 255));
        end
      endcase
      load_step_limits(accel, brake);
      // Hold off the receiver while the sender keeps offering beats
      if (p == 1) rx_holds_asked++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // No idling for a stretch of phase two and for the whole last phase
        idling_on = (p != PHASES - 1) && !(p == 2 && i < 100);
        if (idling_on && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        send_request(random_request());
      end
    end

    in_valid <= 1'b0;
    wait (beats_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("[hbridge_pwm_slew_limiter_unit] OK");
    end else begin
      $display("[hbridge_pwm_slew_limiter_unit] ERROR");
    end
    $finish;
  end

endmodule
